// ===== hw/rtl/dd_avg_pkg.sv =====
// Shared types and constants for the dust density moving-average block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package dd_avg_pkg;

  // Window geometry
  localparam int WINDOW_LEN  = 10;
  localparam int SAMPLE_BITS = 12;

  // Field widths of the transactions and registers
  localparam int SAMPLE_W  = 12;
  localparam int VOLT_W    = 16;
  localparam int DENS_W    = 32;
  localparam int SUPPLY_W  = 13;
  localparam int NODUST_W  = 16;
  localparam int RATIO_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_DUST_MV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Q8   = 2'd2;

  // Register reset values
  localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 13'd3300;
  localparam logic [NODUST_W-1:0] NODUST_RST = 16'd400;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 16'd51;

  // Scaling: mV = mean * supply * 11 >> 12
  localparam int DIVIDER_FACTOR = 11;
  localparam int ADC_FULL_SHIFT = 12;

  // Datapath widths
  localparam int SUM_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int PA_W   = SAMPLE_BITS + SUPPLY_W;
  localparam int PB_W   = PA_W + 4;
  localparam int VFULL_W = PB_W - ADC_FULL_SHIFT;

  // sum / WINDOW_LEN as (sum * RECIP_MULT) >> RECIP_SHIFT, exact for any SUM_W-bit sum
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));

  typedef struct packed {
    logic load;      // take a new sample into the window
    logic div_step;  // mean = sum * reciprocal of WINDOW_LEN
    logic mul_a;     // mean * supply
    logic mul_b;     // * divider factor
    logic volt;      // shift, saturate, threshold
    logic dens;      // excess * ratio
    logic out_load;  // copy results to the output register
  } dd_avg_cmd_t;

endpackage

// ===== hw/rtl/dd_avg_in_if.sv =====
// Input channel: one raw converter sample per transaction.
// Depends on dd_avg_pkg.
interface dd_avg_in_if;
  logic                             valid;
  logic                             ready;
  logic [dd_avg_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/dd_avg_out_if.sv =====
// Result channel: mean, voltage and density per transaction.
// Depends on dd_avg_pkg.
interface dd_avg_out_if;
  logic                            valid;
  logic                            ready;
  logic [dd_avg_pkg::SAMPLE_W-1:0] mean_sample;
  logic [dd_avg_pkg::VOLT_W-1:0]   voltage_mv;
  logic [dd_avg_pkg::DENS_W-1:0]   density_q8;

  modport source (output valid, output mean_sample, output voltage_mv,
                  output density_q8, input ready);
  modport sink   (input valid, input mean_sample, input voltage_mv,
                  input density_q8, output ready);
endinterface

// ===== hw/rtl/dd_avg_ctrl.sv =====
// Sequencer for the moving-average datapath: accept, divide, scale, output.
// Depends on dd_avg_pkg.
module dd_avg_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dd_avg_pkg::dd_avg_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL_A, S_MUL_B, S_VOLT, S_DENS, S_HOLD
  } state_t;

  state_t                       state;
  logic                         out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.mul_a    = (state == S_MUL_A);
    cmd.mul_b    = (state == S_MUL_B);
    cmd.volt     = (state == S_VOLT);
    cmd.dens     = (state == S_DENS);
    cmd.out_load = (state == S_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DIV;
        end
        S_DIV:   state <= S_MUL_A;
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_VOLT;
        S_VOLT:  state <= S_DENS;
        S_DENS:  state <= S_HOLD;
        S_HOLD: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dd_avg_dp.sv =====
// Datapath: sample window, running sum, reciprocal-multiply divide by the
// window length, voltage scaling and density. Depends on dd_avg_pkg.
module dd_avg_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dd_avg_pkg::dd_avg_cmd_t              cmd,
  input  logic [dd_avg_pkg::SAMPLE_W-1:0]      sample,
  input  logic [dd_avg_pkg::SUPPLY_W-1:0]      supply_mv,
  input  logic [dd_avg_pkg::NODUST_W-1:0]      no_dust_mv,
  input  logic [dd_avg_pkg::RATIO_W-1:0]       density_ratio_q8,
  output logic [dd_avg_pkg::SAMPLE_W-1:0]      mean_sample,
  output logic [dd_avg_pkg::VOLT_W-1:0]        voltage_mv,
  output logic [dd_avg_pkg::DENS_W-1:0]        density_q8
);

  localparam int SB = dd_avg_pkg::SAMPLE_BITS;
  localparam int WL = dd_avg_pkg::WINDOW_LEN;
  localparam int SW = dd_avg_pkg::SUM_W;

  logic [SB-1:0]                    window [WL];
  logic [SW-1:0]                    sum;
  logic                             primed;
  logic [SB-1:0]                    quot;
  logic [dd_avg_pkg::PA_W-1:0]      prod_a;
  logic [dd_avg_pkg::PB_W-1:0]      prod_b;
  logic [dd_avg_pkg::VOLT_W-1:0]    volt;
  logic [dd_avg_pkg::VOLT_W-1:0]    excess;
  logic [dd_avg_pkg::DENS_W-1:0]    dens;

  logic [SB-1:0]                    s;
  logic [SW-1:0]                    sum_next;
  logic [dd_avg_pkg::PROD_W-1:0]    recip_prod;
  logic [SB-1:0]                    mean;
  logic [dd_avg_pkg::VFULL_W-1:0]   volt_full;
  logic [dd_avg_pkg::VOLT_W-1:0]    volt_sat;

  assign s    = SB'(sample);
  assign mean = quot;

  always_comb begin
    if (primed) begin
      sum_next = sum - SW'(window[0]) + SW'(s);
    end else begin
      sum_next = SW'(SW'(s) * SW'(WL));
    end
  end

  // divide by the constant window length through its scaled reciprocal
  assign recip_prod = dd_avg_pkg::PROD_W'(sum) * dd_avg_pkg::PROD_W'(dd_avg_pkg::RECIP_MULT);

  assign volt_full = prod_b[dd_avg_pkg::PB_W-1:dd_avg_pkg::ADC_FULL_SHIFT];
  assign volt_sat  = (volt_full > dd_avg_pkg::VFULL_W'({dd_avg_pkg::VOLT_W{1'b1}}))
                   ? {dd_avg_pkg::VOLT_W{1'b1}} : dd_avg_pkg::VOLT_W'(volt_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      sum    <= '0;
    end else if (cmd.load) begin
      primed <= 1'b1;
      sum    <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < WL; i++) begin
        if (!primed) begin
          window[i] <= s;
        end else if (i == WL - 1) begin
          window[i] <= s;
        end else begin
          window[i] <= window[i+1];
        end
      end
    end
    if (cmd.div_step) quot <= recip_prod[dd_avg_pkg::RECIP_SHIFT +: SB];
    if (cmd.mul_a) prod_a <= dd_avg_pkg::PA_W'(mean) * dd_avg_pkg::PA_W'(supply_mv);
    if (cmd.mul_b) begin
      prod_b <= dd_avg_pkg::PB_W'(prod_a) *
                dd_avg_pkg::PB_W'(dd_avg_pkg::DIVIDER_FACTOR);
    end
    if (cmd.volt) begin
      volt   <= volt_sat;
      excess <= (volt_sat >= no_dust_mv) ? volt_sat - no_dust_mv : '0;
    end
    if (cmd.dens) begin
      dens <= dd_avg_pkg::DENS_W'(excess) * dd_avg_pkg::DENS_W'(density_ratio_q8);
    end
    if (cmd.out_load) begin
      mean_sample <= dd_avg_pkg::SAMPLE_W'(mean);
      voltage_mv  <= volt;
      density_q8  <= dens;
    end
  end

endmodule

// ===== hw/rtl/dust_density_moving_average_top.sv =====
// Top level of the dust density moving-average block: configuration registers,
// controller and datapath. Depends on dd_avg_pkg, dd_avg_in_if, dd_avg_out_if.
//
//   channel   direction  payload                                  handshake
//   samples   in         sample[11:0]                             valid/ready
//   results   out        mean_sample, voltage_mv, density_q8      valid/ready
//   cfg       in         cfg_index[1:0], cfg_data[15:0]           cfg_we
//
// After acceptance a sample passes through the controller states S_DIV (the
// reciprocal-multiply divide by the window length), S_MUL_A, S_MUL_B, S_VOLT
// and S_DENS (scaling, saturation and density), then S_HOLD (output load). The
// next sample is not accepted until the controller is back from S_HOLD to idle.
// A new sample is taken only when the controller is idle; a finished result
// waits in the output register while the next sample is processed, and the
// datapath stalls before its output load if that register is still full.
// Reset is synchronous; it clears control state, primed flag and running sum.
module dust_density_moving_average_top (
  input  logic                               clk,
  input  logic                               rst,
  dd_avg_in_if.sink                          samples,
  dd_avg_out_if.source                       results,
  input  logic                               cfg_we,
  input  logic [dd_avg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dd_avg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [dd_avg_pkg::SUPPLY_W-1:0] supply_mv;
  logic [dd_avg_pkg::NODUST_W-1:0] no_dust_mv;
  logic [dd_avg_pkg::RATIO_W-1:0]  density_ratio_q8;
  dd_avg_pkg::dd_avg_cmd_t         cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv        <= dd_avg_pkg::SUPPLY_RST;
      no_dust_mv       <= dd_avg_pkg::NODUST_RST;
      density_ratio_q8 <= dd_avg_pkg::RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dd_avg_pkg::CFG_SUPPLY_MV:  supply_mv        <= cfg_data[dd_avg_pkg::SUPPLY_W-1:0];
        dd_avg_pkg::CFG_NO_DUST_MV: no_dust_mv       <= cfg_data[dd_avg_pkg::NODUST_W-1:0];
        dd_avg_pkg::CFG_RATIO_Q8:   density_ratio_q8 <= cfg_data[dd_avg_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  dd_avg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  dd_avg_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sample           (samples.sample),
    .supply_mv        (supply_mv),
    .no_dust_mv       (no_dust_mv),
    .density_ratio_q8 (density_ratio_q8),
    .mean_sample      (results.mean_sample),
    .voltage_mv       (results.voltage_mv),
    .density_q8       (results.density_q8)
  );

endmodule
